// ----- hw/rtl/mes_pkg.sv -----
// mes_pkg: shared widths, register indexes, function codes and types
// for the Morse element sequencer. No dependencies.
package mes_pkg;

   localparam int CODE_W = 8;
   localparam int DOT_W  = 11;
   localparam int DUR_W  = 14;
   localparam int CNT_W  = $clog2(CODE_W + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = DOT_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_MS     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FARNSWORTH = 1'b1;

   localparam logic [DOT_W-1:0] DOT_MS_RESET      = 11'd80;
   localparam logic [DUR_W-1:0] FARNSWORTH_GAP_MS = 14'd720;

   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_WORD = 1'b1;

   typedef struct packed {
      logic [DUR_W-1:0] unit;
      logic [DUR_W-1:0] dah;
      logic [DUR_W-1:0] letter_gap;
      logic [DUR_W-1:0] word_gap;
   } durations_type;

endpackage

// ----- hw/rtl/mes_req_if.sv -----
// mes_req_if: input channel, valid/ready with character code payload.
// Depends on mes_pkg.
interface mes_req_if import mes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [CODE_W-1:0] code_byte;

   modport source (output valid, output func, output code_byte, input ready);
   modport sink   (input valid, input func, input code_byte, output ready);
endinterface

// ----- hw/rtl/mes_rsp_if.sv -----
// mes_rsp_if: result channel, valid/ready with one key segment per transfer.
// Depends on mes_pkg.
interface mes_rsp_if import mes_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             key_down;
   logic [DUR_W-1:0] duration_ms;
   logic             last;

   modport source (output valid, output key_down, output duration_ms, output last,
                   input ready);
   modport sink   (input valid, input key_down, input duration_ms, input last,
                   output ready);
endinterface

// ----- hw/rtl/mes_csr.sv -----
// mes_csr: configuration registers and the segment durations derived from them.
// Depends on mes_pkg.
module mes_csr import mes_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output durations_type          durations
);

   logic [DOT_W-1:0] dot_ms_ff;
   logic             farnsworth_ff;
   logic [DUR_W-1:0] unit;
   logic [DUR_W-1:0] triple;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ms_ff     <= DOT_MS_RESET;
         farnsworth_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DOT_MS:     dot_ms_ff     <= csr_data;
            CSR_FARNSWORTH: farnsworth_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign unit   = {{(DUR_W-DOT_W){1'b0}}, dot_ms_ff};
   assign triple = unit + (unit << 1);

   assign durations.unit       = unit;
   assign durations.dah        = triple;
   assign durations.letter_gap = farnsworth_ff ? FARNSWORTH_GAP_MS : triple;
   assign durations.word_gap   = (unit << 3) - unit;

endmodule

// ----- hw/rtl/morse_element_sequencer.sv -----
// morse_element_sequencer: turns Morse code bytes and word-gap requests into
// timed key segments. Depends on mes_pkg, mes_req_if, mes_rsp_if, mes_csr.
//
//   channel   direction  per transfer
//   req_chan  in         func, code_byte
//   rsp_chan  out        key_down, duration_ms, last
//   csr_*     in         register write, no handshake
//
// Code bits are scanned one per cycle down to the start marker (all eight
// when there is none). A character is accepted, scanned, then sent as 2n+1
// segments for n elements (each element followed by a unit gap, then the
// letter gap), with a turnaround step before the letter gap. A word gap
// is one segment. req ready is high only between items. A stalled
// result holds in the output register and the sequencer waits on it.
// Reset restores dot_ms 80 and Farnsworth off.
module morse_element_sequencer import mes_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   mes_req_if.sink                req_chan,
   mes_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_ON, ST_OFF, ST_GAP, ST_WORD
   } state_type;

   durations_type     durations;
   state_type         state_ff, state_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic              key_ff, key_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              last_ff, last_in;
   logic              out_free;

   mes_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .durations (durations)
   );

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      key_in   = key_ff;
      dur_in   = dur_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.func == FUNC_WORD) begin
                  state_in = ST_WORD;
               end else begin
                  shift_in = req_chan.code_byte;
                  cnt_in   = CNT_W'(CODE_W);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = ST_GAP;
            end else begin
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
               if (shift_ff[CODE_W-1]) state_in = ST_ON;
            end
         end
         ST_ON: begin
            if (cnt_ff == '0) begin
               state_in = ST_GAP;
            end else if (out_free) begin
               valid_in = 1'b1;
               key_in   = 1'b1;
               dur_in   = shift_ff[CODE_W-1] ? durations.dah : durations.unit;
               last_in  = 1'b0;
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_OFF;
            end
         end
         ST_OFF: begin
            if (out_free) begin
               valid_in = 1'b1;
               key_in   = 1'b0;
               dur_in   = durations.unit;
               last_in  = 1'b0;
               state_in = ST_ON;
            end
         end
         ST_GAP: begin
            if (out_free) begin
               valid_in = 1'b1;
               key_in   = 1'b0;
               dur_in   = durations.letter_gap;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WORD: begin
            if (out_free) begin
               valid_in = 1'b1;
               key_in   = 1'b0;
               dur_in   = durations.word_gap;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      shift_ff <= shift_in;
      key_ff   <= key_in;
      dur_ff   <= dur_in;
      last_ff  <= last_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.key_down    = key_ff;
   assign rsp_chan.duration_ms = dur_ff;
   assign rsp_chan.last        = last_ff;

endmodule
